@@ rtl/length_prefixed_to_start_code_defines.svh @@
// assertion macros shared by the checker
`ifndef LENGTH_PREFIXED_TO_START_CODE_DEFINES_SVH
`define LENGTH_PREFIXED_TO_START_CODE_DEFINES_SVH

// same-cycle implication, off while in reset
`define LPSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define LPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset as well
`define LPSC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lpsc_pkg.sv @@
`timescale 1ns / 1ps
package lpsc_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
  localparam int PREFIX_W        = 3;

  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 3'd4;
  localparam logic [PREFIX_W-1:0] PREFIX_MIN   = 3'd1;
  localparam logic [PREFIX_W-1:0] PREFIX_MAX   = 3'd4;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  // what the back end must emit for one input word
  typedef enum logic [1:0] {
    CMD_START,     // 00 00 00 01
    CMD_BYTE,      // payload byte
    CMD_BYTE_END,  // payload byte, then end marker
    CMD_END        // end marker only
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    status_t    status;
  } cmd_t;

  localparam logic [1:0] START_LAST_IDX = 2'd3;
  localparam logic [1:0] BYTE_END_IDX   = 2'd1;

endpackage

@@ rtl/lpsc_front.sv @@
`timescale 1ns / 1ps
module lpsc_front #(
  parameter int LENGTH_BITS = lpsc_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpsc_pkg::PREFIX_W-1:0]  cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           in_tlast,
  input  logic                           q_full,
  output logic                           q_push,
  output lpsc_pkg::cmd_t                 q_cmd
);

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [2:0]                    cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0]        acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0]        rem_r, rem_nxt;
  lpsc_pkg::status_t             err_r, err_nxt;
  logic [lpsc_pkg::PREFIX_W-1:0] prefix_r;

  logic [lpsc_pkg::PREFIX_W-1:0] eff;
  logic [LENGTH_BITS+7:0]        acc_cat;
  logic [LENGTH_BITS-1:0]        acc_new;
  logic [2:0]                    cnt_inc;
  logic [LENGTH_BITS-1:0]        rem_dec;
  logic                          accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (prefix_r == '0) begin
      eff = lpsc_pkg::PREFIX_MIN;
    end else if (prefix_r > lpsc_pkg::PREFIX_MAX) begin
      eff = lpsc_pkg::PREFIX_MAX;
    end else begin
      eff = prefix_r;
    end
  end

  // lengths that overflow the accumulator stick at all ones
  assign acc_cat = {acc_r, in_tdata};
  assign acc_new = (acc_r[LENGTH_BITS-1 -: 8] != 8'd0) ? '1 : acc_cat[LENGTH_BITS-1:0];
  assign cnt_inc = (cnt_r != 3'd7) ? cnt_r + 3'd1 : cnt_r;
  assign rem_dec = (rem_r != '0) ? rem_r - LENGTH_BITS'(1) : rem_r;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    err_nxt       = err_r;
    q_push        = 1'b0;
    q_cmd.kind    = lpsc_pkg::CMD_END;
    q_cmd.data    = in_tdata;
    q_cmd.status  = lpsc_pkg::ST_OK;
    if (accept) begin
      unique case (phase_r)
        PH_PREFIX: begin
          acc_nxt = acc_new;
          cnt_nxt = cnt_inc;
          if (cnt_inc < eff) begin
            if (in_tlast) begin
              q_push       = 1'b1;
              q_cmd.status = lpsc_pkg::ST_TRUNC;
            end
          end else if (acc_new == '0) begin
            cnt_nxt = 3'd0;
            if (in_tlast) begin
              q_push       = 1'b1;
              q_cmd.status = lpsc_pkg::ST_ZERO;
            end else begin
              phase_nxt = PH_DISCARD;
              err_nxt   = lpsc_pkg::ST_ZERO;
            end
          end else if (in_tlast) begin
            q_push       = 1'b1;
            q_cmd.status = lpsc_pkg::ST_TRUNC;
          end else begin
            rem_nxt    = acc_new;
            acc_nxt    = '0;
            cnt_nxt    = 3'd0;
            phase_nxt  = PH_PAYLOAD;
            q_push     = 1'b1;
            q_cmd.kind = lpsc_pkg::CMD_START;
          end
        end
        PH_PAYLOAD: begin
          q_push  = 1'b1;
          rem_nxt = rem_dec;
          if (in_tlast) begin
            q_cmd.kind   = lpsc_pkg::CMD_BYTE_END;
            q_cmd.status = (rem_dec != '0) ? lpsc_pkg::ST_TRUNC : lpsc_pkg::ST_OK;
          end else begin
            q_cmd.kind = lpsc_pkg::CMD_BYTE;
            if (rem_dec == '0) begin
              phase_nxt = PH_PREFIX;
              cnt_nxt   = 3'd0;
              acc_nxt   = '0;
            end
          end
        end
        default: begin
          if (in_tlast) begin
            q_push       = 1'b1;
            q_cmd.status = err_r;
          end
        end
      endcase
      // every frame end returns the parser to a clean state
      if (in_tlast) begin
        phase_nxt = PH_PREFIX;
        cnt_nxt   = 3'd0;
        acc_nxt   = '0;
        rem_nxt   = '0;
        err_nxt   = lpsc_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      cnt_r    <= 3'd0;
      acc_r    <= '0;
      rem_r    <= '0;
      err_r    <= lpsc_pkg::ST_OK;
      prefix_r <= lpsc_pkg::PREFIX_RESET;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      err_r   <= err_nxt;
      if (cfg_valid && cfg_ready) begin
        prefix_r <= cfg_data;
      end
    end
  end

endmodule

@@ rtl/lpsc_fifo.sv @@
`timescale 1ns / 1ps
module lpsc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpsc_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output lpsc_pkg::cmd_t rd_cmd,
  output logic           full,
  output logic           empty
);

  localparam int AW = lpsc_pkg::FIFO_AW;

  lpsc_pkg::cmd_t mem_r [lpsc_pkg::FIFO_DEPTH];
  logic [AW:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]    rd_ptr_r, rd_ptr_nxt;

  assign empty  = (wr_ptr_r == rd_ptr_r);
  assign full   = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign rd_cmd = mem_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (AW+1)'(push && !full);
  assign rd_ptr_nxt = rd_ptr_r + (AW+1)'(pop && !empty);

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

endmodule

@@ rtl/lpsc_back.sv @@
`timescale 1ns / 1ps
module lpsc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lpsc_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata,
  output logic           out_tlast
);

  logic               valid_r;
  logic [7:0]         data_r;
  logic               end_r;
  lpsc_pkg::status_t  status_r;
  logic [1:0]         idx_r, idx_nxt;

  logic               load;
  logic [7:0]         w_data;
  logic               w_end;
  lpsc_pkg::status_t  w_status;
  logic               w_final;

  // expand one command into its output words, one word per cycle while out_tready is high
  always_comb begin
    w_data   = q_cmd.data;
    w_end    = 1'b0;
    w_status = lpsc_pkg::ST_OK;
    w_final  = 1'b1;
    unique case (q_cmd.kind)
      lpsc_pkg::CMD_START: begin
        w_data  = (idx_r == lpsc_pkg::START_LAST_IDX) ? lpsc_pkg::SC_ONE : lpsc_pkg::SC_ZERO;
        w_final = (idx_r == lpsc_pkg::START_LAST_IDX);
      end
      lpsc_pkg::CMD_BYTE: begin
        w_final = 1'b1;
      end
      lpsc_pkg::CMD_BYTE_END: begin
        if (idx_r == lpsc_pkg::BYTE_END_IDX) begin
          w_data   = 8'd0;
          w_end    = 1'b1;
          w_status = q_cmd.status;
        end else begin
          w_final = 1'b0;
        end
      end
      lpsc_pkg::CMD_END: begin
        w_data   = 8'd0;
        w_end    = 1'b1;
        w_status = q_cmd.status;
      end
      default: begin
        w_final = 1'b1;
      end
    endcase
  end

  assign load    = !valid_r || out_tready;
  assign q_pop   = load && !q_empty && w_final;
  assign idx_nxt = (load && !q_empty) ? (w_final ? 2'd0 : idx_r + 2'd1) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      data_r   <= w_data;
      end_r    <= w_end;
      status_r <= w_status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, status_r, data_r};
  assign out_tlast  = end_r;

endmodule

@@ rtl/length_prefixed_to_start_code.sv @@
`timescale 1ns / 1ps
// Converts length-prefixed video units to start-code framing, one byte per word.
// in_*  : frame bytes; in_tlast marks the final byte of a frame.
// cfg_* : prefix length in bytes (1..4, 0 acts as 1, above 4 as 4), reset value 4;
//         write it only while no frame is in flight.
// out_* : start code bytes and payload bytes; each frame closes with one marker word
//         (out_tlast high, byte 0) whose status field is 0 ok, 1 zero unit length,
//         2 truncated unit. After an error the rest of the frame is dropped.
// Throughput: one input byte per cycle. A prefix turns into four output words, so
// the output side sets the sustained rate: a four-entry command queue between the
// parser and the output sequencer absorbs the start codes, and in_tready falls only
// once that queue is full.
// With the queue empty, an accepted byte is written into the command queue, then loaded
// into the output register, from which it is presented on out_*.
// Reset clears the parser, the queue and the output valid flag; out_tvalid is low.
// A stalled receiver holds the output word steady; the queue fills and then
// in_tready goes low until words drain.
module length_prefixed_to_start_code #(
  parameter int LENGTH_BITS = lpsc_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpsc_pkg::PREFIX_W-1:0] cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // data_in[7:0]
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // data_out[7:0], frame_status[9:8]
  output logic                          out_tlast
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  lpsc_pkg::cmd_t q_wr_cmd;
  lpsc_pkg::cmd_t q_rd_cmd;

  lpsc_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_wr_cmd)
  );

  lpsc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  lpsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_rd_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/lpsc_checker.sv @@
`timescale 1ns / 1ps
`include "length_prefixed_to_start_code_defines.svh"
module lpsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // nothing may leave the block in the cycle after reset
  `LPSC_ASSERT_RST(a_reset_idle, !rst_n, !out_tvalid, "output valid right after reset")

  // a stalled word stays put
  `LPSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output word changed under stall")

  // end marker carries no byte and a defined status
  `LPSC_ASSERT_NOW(a_marker_form, out_tvalid && out_tlast,
    out_tdata[7:0] == 8'd0 && out_tdata[9:8] != 2'd3, "malformed end marker")

  // byte words carry a clear status field
  `LPSC_ASSERT_NOW(a_byte_status, out_tvalid && !out_tlast,
    out_tdata[15:8] == 8'd0, "status set on a byte word")

endmodule

bind length_prefixed_to_start_code lpsc_checker u_lpsc_checker (.*);
